// ===== rtl/core/iirf_pkg.sv =====
`timescale 1ns / 1ps

package iirf_pkg;

    // field and register widths
    localparam int SAMPLE_W   = 16;
    localparam int DATA_W     = 32;
    localparam int COEF_W     = 20;
    localparam int WEIGHT_W   = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;
    localparam int MUL_B_W    = 30;
    localparam int PROD_W     = DATA_W + MUL_B_W;
    localparam int QSHIFT     = 17;
    localparam int NUM_FF     = 3;
    localparam int NUM_FB     = 2;

    // ewma divide by 1000 as a reciprocal multiply, exact for any 32-bit signed sum:
    // floor(s * ceil(2^38 / 1000) / 2^38), plus one when s is negative
    localparam int RECIP_SHIFT = 38;
    localparam int QUOT_W      = PROD_W - RECIP_SHIFT;
    localparam logic signed [MUL_B_W-1:0] RECIP_1000 = 30'sh10624DD3;

    // register reset values
    localparam logic                  EWMA_MODE_RST  = 1'b1;
    localparam logic [WEIGHT_W-1:0]   NEW_WEIGHT_RST = 10'd1000;
    localparam logic [WEIGHT_W-1:0]   OLD_WEIGHT_RST = 10'd0;
    localparam logic [COEF_W-1:0]     FF0_COEFF_RST  = 20'd131072;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_EWMA_MODE  = 3'd0,
        REG_NEW_WEIGHT = 3'd1,
        REG_OLD_WEIGHT = 3'd2,
        REG_FF_COEFF_0 = 3'd3,
        REG_FF_COEFF_1 = 3'd4,
        REG_FF_COEFF_2 = 3'd5,
        REG_FB_COEFF_1 = 3'd6,
        REG_FB_COEFF_2 = 3'd7
    } t_reg_idx;

    // multiplier operand selection
    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_FF,
        MUL_FB,
        MUL_NEW,
        MUL_OLD,
        MUL_RECIP
    } t_mul_op;

    // accumulator operation
    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_CLR,
        ACC_PROD
    } t_acc_op;

    // loop index operation
    typedef enum logic [1:0] {
        IDX_HOLD,
        IDX_CLR,
        IDX_LOOP
    } t_idx_op;

    // sequencer branch kind
    typedef enum logic [2:0] {
        J_NEXT,
        J_GOTO,
        J_START,
        J_LOOP_FF,
        J_LOOP_FB,
        J_EMIT
    } t_jmp;

    localparam int PC_W = 4;
    typedef logic [PC_W-1:0] t_pc;

    // one microcode word
    typedef struct packed {
        t_mul_op mul;
        t_acc_op acc;
        t_idx_op idx;
        t_jmp    jmp;
        logic    load;
        logic    emit;
        t_pc     target;
    } t_ctrl;

    // program addresses
    localparam t_pc P_IDLE   = 4'd0;
    localparam t_pc P_FF     = 4'd1;
    localparam t_pc P_FB     = 4'd2;
    localparam t_pc P_LAST   = 4'd3;
    localparam t_pc P_E_NEW  = 4'd4;
    localparam t_pc P_E_OLD  = 4'd5;
    localparam t_pc P_E_ADD  = 4'd6;
    localparam t_pc P_E_MUL  = 4'd7;
    localparam t_pc P_E_QUOT = 4'd8;
    localparam t_pc P_EMIT   = 4'd9;

    // microcode rom
    function automatic t_ctrl prog_word(input t_pc pc);
        t_ctrl w;
        w.mul    = MUL_NONE;
        w.acc    = ACC_HOLD;
        w.idx    = IDX_HOLD;
        w.jmp    = J_NEXT;
        w.load   = 1'b0;
        w.emit   = 1'b0;
        w.target = P_IDLE;
        case (pc)
            P_IDLE: begin
                w.acc    = ACC_CLR;
                w.idx    = IDX_CLR;
                w.jmp    = J_START;
                w.load   = 1'b1;
                w.target = P_E_NEW;
            end
            P_FF: begin
                w.mul    = MUL_FF;
                w.acc    = ACC_PROD;
                w.idx    = IDX_LOOP;
                w.jmp    = J_LOOP_FF;
                w.target = P_FF;
            end
            P_FB: begin
                w.mul    = MUL_FB;
                w.acc    = ACC_PROD;
                w.idx    = IDX_LOOP;
                w.jmp    = J_LOOP_FB;
                w.target = P_FB;
            end
            P_LAST: begin
                w.acc    = ACC_PROD;
                w.jmp    = J_GOTO;
                w.target = P_EMIT;
            end
            P_E_NEW: begin
                w.mul = MUL_NEW;
                w.acc = ACC_PROD;
            end
            P_E_OLD: begin
                w.mul = MUL_OLD;
                w.acc = ACC_PROD;
            end
            P_E_ADD: begin
                w.acc = ACC_PROD;
            end
            P_E_MUL: begin
                w.mul = MUL_RECIP;
            end
            P_E_QUOT: begin
                w.acc = ACC_PROD;
            end
            P_EMIT: begin
                w.emit   = 1'b1;
                w.jmp    = J_EMIT;
                w.target = P_IDLE;
            end
            default: begin
                w.jmp    = J_GOTO;
                w.target = P_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/core/iir_or_ewma_sample_filter.sv =====
`timescale 1ns / 1ps
// Per-sample filter, exponential weighted average or direct-form-I IIR.
// Input channel: i_valid / o_ready / i_sample, one signed 16-bit sample per
// transfer. Output channel: o_valid / i_ready / o_filtered, one signed 32-bit
// value per input sample, in order.
// Configuration: i_cfg_wr_en / i_cfg_index / i_cfg_data write one register
// per cycle; write only while no sample is in flight.
// A sample walks through a microcode program on one shared 32x30 multiplier.
// IIR mode: the program takes one step per feed-forward tap, one per
// feedback tap, plus drain and emit steps, from input transfer to o_valid.
// EWMA mode: steps for the two weight products, their sum, a reciprocal
// multiply for the divide by 1000 and its quotient, then emit. In either
// mode a new sample is taken only once the program is back at idle.
// The result sits in an output register, so the next sample is taken while
// it waits. If the receiver still stalls when the following result is done,
// the program holds at its emit step and o_ready stays low.
// Reset (synchronous, active low) clears both histories and the output
// valid flag, and restores the register defaults (EWMA mode, pass-through).
module iir_or_ewma_sample_filter
    import iirf_pkg::*;
#(
    parameter int ORDER = 2
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [CFG_DATA_W-1:0]        i_cfg_data,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [SAMPLE_W-1:0]   i_sample,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic signed [DATA_W-1:0]     o_filtered
);

    localparam int IN_DEPTH  = ORDER + 1;
    localparam int OUT_DEPTH = ORDER;
    localparam int TAP_W     = $clog2(IN_DEPTH);
    localparam int IDX_W     = TAP_W;

    // configuration registers
    logic                       r_ewma_mode;
    logic [WEIGHT_W-1:0]        r_new_weight;
    logic [WEIGHT_W-1:0]        r_old_weight;
    logic signed [COEF_W-1:0]   r_ff_coeff [NUM_FF];
    logic signed [COEF_W-1:0]   r_fb_coeff [NUM_FB];

    // sequencer state
    t_pc                        r_pc;
    t_pc                        n_pc;
    logic [IDX_W-1:0]           r_idx;
    t_mul_op                    r_kind;
    t_ctrl                      ctrl;
    logic                       go;
    logic                       loop_more;
    logic                       in_xfer;
    logic                       out_free;

    // datapath state
    logic signed [SAMPLE_W-1:0] r_sample;
    logic signed [SAMPLE_W-1:0] r_in_hist  [IN_DEPTH];
    logic signed [DATA_W-1:0]   r_out_hist [OUT_DEPTH];
    logic signed [PROD_W-1:0]   r_prod;
    logic [DATA_W-1:0]          r_acc;
    logic                       r_out_valid;
    logic signed [DATA_W-1:0]   r_out_data;

    // combinational datapath
    logic signed [SAMPLE_W-1:0] tap_in;
    logic signed [DATA_W-1:0]   tap_out;
    logic signed [COEF_W-1:0]   ff_c;
    logic signed [COEF_W-1:0]   fb_c;
    logic signed [DATA_W-1:0]   mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic signed [PROD_W-1:0]   mul_out;
    logic [DATA_W-1:0]          term_q;
    logic [DATA_W-1:0]          quot;
    logic [DATA_W-1:0]          acc_sum;

    assign ctrl     = prog_word(r_pc);
    assign o_ready  = (r_pc == P_IDLE);
    assign in_xfer  = i_valid && o_ready;
    assign out_free = !r_out_valid || i_ready;

    assign o_valid    = r_out_valid;
    assign o_filtered = r_out_data;

    // sequencer branch and stall
    always_comb begin
        n_pc      = t_pc'(r_pc + 1'b1);
        go        = 1'b1;
        loop_more = 1'b0;
        case (ctrl.jmp)
            J_NEXT: begin
                n_pc = t_pc'(r_pc + 1'b1);
            end
            J_GOTO: begin
                n_pc = ctrl.target;
            end
            J_START: begin
                go   = in_xfer;
                n_pc = r_ewma_mode ? ctrl.target : t_pc'(r_pc + 1'b1);
            end
            J_LOOP_FF: begin
                loop_more = (r_idx != IDX_W'(ORDER));
                n_pc      = loop_more ? ctrl.target : t_pc'(r_pc + 1'b1);
            end
            J_LOOP_FB: begin
                loop_more = (r_idx != IDX_W'(ORDER - 1));
                n_pc      = loop_more ? ctrl.target : t_pc'(r_pc + 1'b1);
            end
            J_EMIT: begin
                go   = out_free;
                n_pc = ctrl.target;
            end
            default: begin
                n_pc = P_IDLE;
            end
        endcase
    end

    // tap and coefficient selection by loop index
    always_comb begin
        tap_in  = '0;
        tap_out = '0;
        ff_c    = '0;
        fb_c    = '0;
        for (int i = 0; i < IN_DEPTH; i++) begin
            if (r_idx == IDX_W'(i)) begin
                tap_in = r_in_hist[i];
            end
        end
        for (int i = 0; i < OUT_DEPTH; i++) begin
            if (r_idx == IDX_W'(i)) begin
                tap_out = r_out_hist[i];
            end
        end
        // taps past the configured coefficients weigh zero
        for (int i = 0; i < NUM_FF && i < IN_DEPTH; i++) begin
            if (r_idx == IDX_W'(i)) begin
                ff_c = r_ff_coeff[i];
            end
        end
        for (int i = 0; i < NUM_FB && i < OUT_DEPTH; i++) begin
            if (r_idx == IDX_W'(i)) begin
                fb_c = r_fb_coeff[i];
            end
        end
    end

    // shared multiplier operands
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (ctrl.mul)
            MUL_FF: begin
                mul_a = {{(DATA_W-SAMPLE_W){tap_in[SAMPLE_W-1]}}, tap_in};
                mul_b = {{(MUL_B_W-COEF_W){ff_c[COEF_W-1]}}, ff_c};
            end
            MUL_FB: begin
                mul_a = tap_out;
                mul_b = {{(MUL_B_W-COEF_W){fb_c[COEF_W-1]}}, fb_c};
            end
            MUL_NEW: begin
                mul_a = {{(DATA_W-SAMPLE_W){r_sample[SAMPLE_W-1]}}, r_sample};
                mul_b = {{(MUL_B_W-WEIGHT_W){1'b0}}, r_new_weight};
            end
            MUL_OLD: begin
                mul_a = r_out_hist[0];
                mul_b = {{(MUL_B_W-WEIGHT_W){1'b0}}, r_old_weight};
            end
            MUL_RECIP: begin
                mul_a = r_acc;
                mul_b = RECIP_1000;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_out = mul_a * mul_b;

    // accumulate the registered product, q17 taps floor-shifted
    assign term_q = r_prod[QSHIFT+DATA_W-1:QSHIFT];

    // floored reciprocal product, the sign bit below turns it into truncation
    assign quot = {{(DATA_W-QUOT_W){r_prod[PROD_W-1]}}, r_prod[PROD_W-1:RECIP_SHIFT]};

    always_comb begin
        case (r_kind)
            MUL_FF:    acc_sum = r_acc + term_q;
            MUL_FB:    acc_sum = r_acc - term_q;
            MUL_NEW:   acc_sum = r_acc + r_prod[DATA_W-1:0];
            MUL_OLD:   acc_sum = r_acc + r_prod[DATA_W-1:0];
            MUL_RECIP: acc_sum = quot + {{(DATA_W-1){1'b0}}, r_acc[DATA_W-1]};
            default:   acc_sum = r_acc;
        endcase
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ewma_mode   <= EWMA_MODE_RST;
            r_new_weight  <= NEW_WEIGHT_RST;
            r_old_weight  <= OLD_WEIGHT_RST;
            r_ff_coeff[0] <= FF0_COEFF_RST;
            r_ff_coeff[1] <= '0;
            r_ff_coeff[2] <= '0;
            r_fb_coeff[0] <= '0;
            r_fb_coeff[1] <= '0;
        end else if (i_cfg_wr_en) begin
            case (t_reg_idx'(i_cfg_index))
                REG_EWMA_MODE:  r_ewma_mode   <= i_cfg_data[0];
                REG_NEW_WEIGHT: r_new_weight  <= i_cfg_data[WEIGHT_W-1:0];
                REG_OLD_WEIGHT: r_old_weight  <= i_cfg_data[WEIGHT_W-1:0];
                REG_FF_COEFF_0: r_ff_coeff[0] <= i_cfg_data;
                REG_FF_COEFF_1: r_ff_coeff[1] <= i_cfg_data;
                REG_FF_COEFF_2: r_ff_coeff[2] <= i_cfg_data;
                REG_FB_COEFF_1: r_fb_coeff[0] <= i_cfg_data;
                REG_FB_COEFF_2: r_fb_coeff[1] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer, histories and output handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= P_IDLE;
            r_idx       <= '0;
            r_kind      <= MUL_NONE;
            r_out_valid <= 1'b0;
            for (int i = 0; i < IN_DEPTH; i++) begin
                r_in_hist[i] <= '0;
            end
            for (int i = 0; i < OUT_DEPTH; i++) begin
                r_out_hist[i] <= '0;
            end
        end else begin
            if (go) begin
                r_pc   <= n_pc;
                r_kind <= ctrl.mul;
                case (ctrl.idx)
                    IDX_CLR:  r_idx <= '0;
                    IDX_LOOP: r_idx <= loop_more ? IDX_W'(r_idx + 1'b1) : '0;
                    default:  r_idx <= r_idx;
                endcase
            end
            // iir mode pushes the new sample into the input history
            if (go && ctrl.load && !r_ewma_mode) begin
                r_in_hist[0] <= i_sample;
                for (int i = 1; i < IN_DEPTH; i++) begin
                    r_in_hist[i] <= r_in_hist[i-1];
                end
            end
            // every result enters the output history
            if (go && ctrl.emit) begin
                r_out_hist[0] <= r_acc;
                for (int i = 1; i < OUT_DEPTH; i++) begin
                    r_out_hist[i] <= r_out_hist[i-1];
                end
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (go) begin
            if (ctrl.load) begin
                r_sample <= i_sample;
            end
            if (ctrl.mul != MUL_NONE) begin
                r_prod <= mul_out;
            end
            if (ctrl.emit) begin
                r_out_data <= r_acc;
            end
            case (ctrl.acc)
                ACC_CLR: begin
                    r_acc <= '0;
                end
                ACC_PROD: begin
                    r_acc <= acc_sum;
                end
                default: ;
            endcase
        end
    end

endmodule

// ===== sim/iirf_filter_checker.sv =====
`timescale 1ns / 1ps

module iirf_filter_checker
    import iirf_pkg::*;
#(
    parameter int ORDER = 2
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                       i_in_valid,
    input  logic                       i_in_ready,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic                       i_out_valid,
    input  logic                       i_out_ready,
    input  logic signed [DATA_W-1:0]   i_filtered,
    output int                         o_fail_cnt,
    output int                         o_pending
);

    localparam int IN_DEPTH  = ORDER + 1;

    // shadow copy of the register file
    logic                     ewma_on;
    logic [WEIGHT_W-1:0]      new_wt;
    logic [WEIGHT_W-1:0]      old_wt;
    logic signed [COEF_W-1:0] ff_coef [NUM_FF];
    logic signed [COEF_W-1:0] fb_coef [1:NUM_FB];

    // filter state
    logic signed [SAMPLE_W-1:0] x_hist [IN_DEPTH];
    logic signed [DATA_W-1:0]   y_hist [ORDER];
    int unsigned                head;
    logic signed [DATA_W-1:0]   y_last;

    // filtered values still owed by the block, oldest first
    logic signed [DATA_W-1:0] filtered_due [$];

    // one sample through the filter, updates the histories
    function automatic logic signed [DATA_W-1:0] next_filtered(
        input logic signed [SAMPLE_W-1:0] x
    );
        logic [DATA_W-1:0]        acc;
        logic [DATA_W-1:0]        xs;
        logic signed [DATA_W-1:0] y;
        longint                   coef;
        longint                   prod;
        if (ewma_on) begin
            // products and sum wrap at 32 bits, divide truncates toward zero
            xs  = {{(DATA_W - SAMPLE_W){x[SAMPLE_W-1]}}, x};
            acc = xs * DATA_W'(new_wt) + y_last * DATA_W'(old_wt);
            y   = $signed(acc) / 1000;
        end else begin
            head = (head + IN_DEPTH - 1) % IN_DEPTH;
            x_hist[head] = x;
            acc = '0;
            // feed-forward taps, newest first, floor shift per product
            for (int i = 0; i < IN_DEPTH; i++) begin
                coef = 0;
                if (i < NUM_FF) coef = ff_coef[i];
                prod = longint'(x_hist[(head + i) % IN_DEPTH]) * coef;
                acc  = acc + DATA_W'(prod >>> QSHIFT);
            end
            // feedback taps
            for (int i = 1; i <= ORDER; i++) begin
                coef = 0;
                if (i <= NUM_FB) coef = fb_coef[i];
                prod = longint'(y_hist[i-1]) * coef;
                acc  = acc - DATA_W'(prod >>> QSHIFT);
            end
            y = $signed(acc);
        end
        // output history moves in both modes
        for (int i = ORDER - 1; i > 0; i--) y_hist[i] = y_hist[i-1];
        y_hist[0] = y;
        y_last    = y;
        return y;
    endfunction

    initial begin
        o_fail_cnt = 0;
        o_pending  = 0;
    end

    always @(posedge i_clk) begin
        logic signed [DATA_W-1:0] want;
        if (!i_rst_n) begin
            ewma_on = EWMA_MODE_RST;
            new_wt  = NEW_WEIGHT_RST;
            old_wt  = OLD_WEIGHT_RST;
            for (int i = 0; i < NUM_FF; i++) ff_coef[i] = '0;
            for (int i = 1; i <= NUM_FB; i++) fb_coef[i] = '0;
            ff_coef[0] = FF0_COEFF_RST;
            for (int i = 0; i < IN_DEPTH; i++) x_hist[i] = '0;
            for (int i = 0; i < ORDER; i++) y_hist[i] = '0;
            head   = 0;
            y_last = '0;
            filtered_due.delete();
        end else begin
            // register writes
            if (i_cfg_wr_en) begin
                case (t_reg_idx'(i_cfg_index))
                    REG_EWMA_MODE:  ewma_on    = i_cfg_data[0];
                    REG_NEW_WEIGHT: new_wt     = i_cfg_data[WEIGHT_W-1:0];
                    REG_OLD_WEIGHT: old_wt     = i_cfg_data[WEIGHT_W-1:0];
                    REG_FF_COEFF_0: ff_coef[0] = i_cfg_data;
                    REG_FF_COEFF_1: ff_coef[1] = i_cfg_data;
                    REG_FF_COEFF_2: ff_coef[2] = i_cfg_data;
                    REG_FB_COEFF_1: fb_coef[1] = i_cfg_data;
                    REG_FB_COEFF_2: fb_coef[2] = i_cfg_data;
                    default: ;
                endcase
            end
            // result transfer against the oldest owed value
            if (i_out_valid && i_out_ready) begin
                if (filtered_due.size() == 0) begin
                    o_fail_cnt++;
                    $display("%0t: unexpected filtered transfer, expected none, actual %0d",
                             $time, i_filtered);
                end else begin
                    want = filtered_due.pop_front();
                    if (i_filtered !== want) begin
                        o_fail_cnt++;
                        $display("%0t: filtered mismatch, expected %0d, actual %0d",
                                 $time, want, i_filtered);
                    end
                end
            end
            // sample transfer
            if (i_in_valid && i_in_ready) filtered_due.push_back(next_filtered(i_sample));
        end
        o_pending = filtered_due.size();
    end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import iirf_pkg::*;

    localparam int ORDER          = 2;
    localparam int PHASES         = 11;
    localparam int PHASE_ITEMS    = 100;
    localparam int HOLD_AT        = 950;
    localparam int HOLD_LEN       = 300;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 20;

    logic                       clk          = 1'b0;
    logic                       rst_n        = 1'b0;
    logic                       cfg_wr_en    = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index    = '0;
    logic [CFG_DATA_W-1:0]      cfg_data     = '0;
    logic                       in_valid     = 1'b0;
    logic                       in_ready;
    logic signed [SAMPLE_W-1:0] in_sample    = '0;
    logic                       out_valid;
    logic                       out_ready    = 1'b0;
    logic signed [DATA_W-1:0]   out_filtered;

    int fail_cnt;
    int due_cnt;
    int sent_cnt     = 0;
    int src_idle_pct = 27;
    int sink_idle_pct = 53;
    int hold_left    = 0;
    bit hold_done    = 1'b0;
    int stall_cycles = 0;

    // clock, 10 ns period
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    iir_or_ewma_sample_filter #(
        .ORDER(ORDER)
    ) u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_valid     (in_valid),
        .o_ready     (in_ready),
        .i_sample    (in_sample),
        .o_valid     (out_valid),
        .i_ready     (out_ready),
        .o_filtered  (out_filtered)
    );

    iirf_filter_checker #(
        .ORDER(ORDER)
    ) u_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_sample    (in_sample),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_filtered  (out_filtered),
        .o_fail_cnt  (fail_cnt),
        .o_pending   (due_cnt)
    );

    // receiver side, one long hold-off once the stream is well along
    always @(negedge clk) begin
        if (!hold_done && sent_cnt >= HOLD_AT) begin
            hold_left = HOLD_LEN;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // watchdog on cycles with no transfer at all
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en || !rst_n) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // one sample transfer, called and left at a falling edge
    task automatic send_sample(input logic [SAMPLE_W-1:0] x);
        while ($urandom_range(99) < src_idle_pct) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid  = 1'b1;
        in_sample = x;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
        sent_cnt++;
    endtask

    // registers move only with nothing in flight
    task automatic wait_idle();
        in_valid = 1'b0;
        while (due_cnt != 0) @(negedge clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(9))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'($urandom_range(32)) - 16'd16;
            default: return 16'($urandom);
        endcase
    endfunction

    // weights above 1000 are legal, upper data bits are junk
    function automatic logic [CFG_DATA_W-1:0] pick_weight();
        logic [WEIGHT_W-1:0] w;
        case ($urandom_range(5))
            0:       w = 10'd0;
            1:       w = 10'd1000;
            2:       w = 10'd1023;
            default: w = 10'($urandom_range(1023));
        endcase
        return {10'($urandom), w};
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_coeff();
        case ($urandom_range(6))
            0:       return 20'h7FFFF;
            1:       return 20'h80000;
            2:       return 20'h20000;
            3, 4:    return 20'($urandom_range(262144) - 131072);
            default: return 20'($urandom);
        endcase
    endfunction

    initial begin
        // hold reset at the start
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // reset defaults, ewma pass-through at the sample extremes
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_sample(16'h0000);
        send_sample(16'h0001);
        send_sample(16'hFFFF);

        // ewma with weights above 1000, the average grows over the 7FFF samples
        wait_idle();
        write_reg(REG_NEW_WEIGHT, 20'd1023);
        write_reg(REG_OLD_WEIGHT, 20'd1023);
        repeat (4) send_sample(16'h7FFF);
        repeat (2) send_sample(16'h8000);

        // both weights zero
        wait_idle();
        write_reg(REG_NEW_WEIGHT, 20'd0);
        write_reg(REG_OLD_WEIGHT, 20'd0);
        send_sample(16'hFFFB);

        // iir with coefficients at the extremes, one of them at 1.0 in q17
        wait_idle();
        write_reg(REG_EWMA_MODE, 20'd0);
        write_reg(REG_FF_COEFF_0, 20'h7FFFF);
        write_reg(REG_FF_COEFF_1, 20'h80000);
        write_reg(REG_FF_COEFF_2, 20'h20000);
        write_reg(REG_FB_COEFF_1, 20'h80000);
        write_reg(REG_FB_COEFF_2, 20'h7FFFF);
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_sample(16'h0000);
        send_sample(16'h0000);

        // back to ewma, last output left by the iir run feeds in
        wait_idle();
        write_reg(REG_EWMA_MODE, 20'd1);
        write_reg(REG_NEW_WEIGHT, 20'd500);
        write_reg(REG_OLD_WEIGHT, 20'd500);
        send_sample(16'h1234);
        send_sample(16'h8000);

        // random settings and samples, idling swapped from phase 4, then none from phase 8
        for (int ph = 0; ph < PHASES; ph++) begin
            wait_idle();
            if (ph == 4) begin
                src_idle_pct  = 53;
                sink_idle_pct = 27;
            end else if (ph == 8) begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
            write_reg(REG_EWMA_MODE, {19'($urandom), 1'($urandom_range(1))});
            write_reg(REG_NEW_WEIGHT, pick_weight());
            write_reg(REG_OLD_WEIGHT, pick_weight());
            write_reg(REG_FF_COEFF_0, pick_coeff());
            write_reg(REG_FF_COEFF_1, pick_coeff());
            write_reg(REG_FF_COEFF_2, pick_coeff());
            write_reg(REG_FB_COEFF_1, pick_coeff());
            write_reg(REG_FB_COEFF_2, pick_coeff());
            repeat (PHASE_ITEMS) send_sample(pick_sample());
        end

        // drain, then give the block time to show any stray result
        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_cnt == 0 && due_cnt == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/iirf_pkg.sv
rtl/core/iir_or_ewma_sample_filter.sv
sim/iirf_filter_checker.sv
sim/tb.sv
